// File: sv/shift_insert_array_table_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef SHIFT_INSERT_ARRAY_TABLE_DEFINES_SVH
`define SHIFT_INSERT_ARRAY_TABLE_DEFINES_SVH

// Concurrent check of a property, sampled on clk, off while rst_n is low.
`define SIA_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check of an overlapping implication.
`define SIA_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: sv/sia_pkg.sv
// Package: types, codes and constants of the shift-insert array table.
package sia_pkg;

  localparam int DEPTH_DEF      = 32;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int OP_W           = 3;
  localparam int POS_W          = 6;
  localparam int CNT_W          = 6;
  localparam int ST_W           = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_APPEND = 3'd1,
    OP_READ   = 3'd2,
    OP_EDIT   = 3'd3,
    OP_DELETE = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_WRITE  = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_DELETE = 2'd3
  } cell_cmd_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    cell_cmd_t        cmd;
    logic [POS_W-1:0] tgt;
  } cell_ctrl_t;

  // Result fields other than the read data.
  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] fill_count;
    logic             is_empty;
    logic             is_full;
  } out_meta_t;

  typedef struct packed {
    out_meta_t meta;
    logic      rd_hit;
  } ctrl_res_t;

endpackage

// File: sv/shift_insert_array_table.sv
// Top level: ordered list of signed entries held in a row of shifting cells.
//
// Input channel (in_valid / in_stall): one word per operation, made of
// in_opcode (insert, append, read, edit, delete), in_position and in_item_value.
// Result channel (out_valid / out_stall): one word per operation with
// out_status, out_read_data (-1 unless a read succeeds), out_fill_count,
// out_is_empty and out_is_full as they stand after the operation.
// Config channel (cfg_valid / cfg_ready): writes the capacity; the list empties.
// Write it only while no operation is in flight.
// The result word is registered at the outputs once its input word is taken,
// or caught in the skid register below. Throughput: one word per cycle while
// in_stall is low; every cell shifts at once, so any insert or delete position costs the same.
// When the receiver stalls, one further result is caught in a skid register;
// in_stall then rises until that register drains.
// Reset (rst_n low at a clock edge): capacity and fill count clear, no result
// is pending. Entry contents are not cleared; only written entries are read.
module shift_insert_array_table #(
  parameter int DEPTH      = sia_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sia_pkg::DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [sia_pkg::OP_W-1:0]   in_opcode,
  input  logic [sia_pkg::POS_W-1:0]  in_position,
  input  logic [DATA_WIDTH-1:0]      in_item_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sia_pkg::ST_W-1:0]   out_status,
  output logic [DATA_WIDTH-1:0]      out_read_data,
  output logic [sia_pkg::CNT_W-1:0]  out_fill_count,
  output logic                       out_is_empty,
  output logic                       out_is_full,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sia_pkg::CNT_W-1:0]  cfg_capacity_in_use
);
  import sia_pkg::*;

  logic                  in_acc;
  logic                  cfg_we;
  cell_ctrl_t            cell_ctrl;
  ctrl_res_t             res;
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_sel;
  logic [DATA_WIDTH-1:0] new_data;

  logic                  out_valid_r;
  logic                  skid_valid_r;
  out_meta_t             out_meta_r;
  out_meta_t             skid_meta_r;
  logic [DATA_WIDTH-1:0] out_data_r;
  logic [DATA_WIDTH-1:0] skid_data_r;
  logic                  out_free;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid & ~in_stall;

  sia_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .op        (in_opcode),
    .pos       (in_position),
    .cfg_we    (cfg_we),
    .cfg_cap   (cfg_capacity_in_use),
    .cell_ctrl (cell_ctrl),
    .res       (res)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_q;
    logic [DATA_WIDTH-1:0] right_q;

    if (i == 0) begin : g_first
      assign left_q = in_item_value;
    end else begin : g_left
      assign left_q = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_q = cell_q[i];
    end else begin : g_right
      assign right_q = cell_q[i+1];
    end

    sia_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CELL_IDX   (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .wr_data (in_item_value),
      .left_q  (left_q),
      .right_q (right_q),
      .data_q  (cell_q[i])
    );
  end

  // select the addressed entry from the row
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (i == int'(in_position)) rd_sel = cell_q[i];
    end
    new_data = res.rd_hit ? rd_sel : '1;
  end

  assign out_free = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r | in_acc;
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      // hold the new word aside while the output is stalled
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_meta_r <= skid_meta_r;
        out_data_r <= skid_data_r;
      end else if (in_acc) begin
        out_meta_r <= res.meta;
        out_data_r <= new_data;
      end
    end else if (in_acc) begin
      skid_meta_r <= res.meta;
      skid_data_r <= new_data;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_meta_r.status;
  assign out_read_data  = out_data_r;
  assign out_fill_count = out_meta_r.fill_count;
  assign out_is_empty   = out_meta_r.is_empty;
  assign out_is_full    = out_meta_r.is_full;

endmodule

// File: sv/sia_cell.sv
// One storage cell of the row: holds an entry and trades it with its neighbors.
module sia_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CELL_IDX   = 0
) (
  input  logic                   clk,
  input  sia_pkg::cell_ctrl_t    ctrl,
  input  logic [DATA_WIDTH-1:0]  wr_data,
  input  logic [DATA_WIDTH-1:0]  left_q,
  input  logic [DATA_WIDTH-1:0]  right_q,
  output logic [DATA_WIDTH-1:0]  data_q
);
  import sia_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  int                    tgt_i;

  assign tgt_i = int'(ctrl.tgt);

  always_comb begin
    data_nxt = data_r;
    case (ctrl.cmd)
      CELL_WRITE: begin
        if (CELL_IDX == tgt_i) data_nxt = wr_data;
      end
      CELL_INSERT: begin
        // cells above the slot take their lower neighbor
        if (CELL_IDX > tgt_i) data_nxt = left_q;
        else if (CELL_IDX == tgt_i) data_nxt = wr_data;
      end
      CELL_DELETE: begin
        if (CELL_IDX >= tgt_i) data_nxt = right_q;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

// File: sv/sia_ctrl.sv
// Control: capacity and fill count registers, index and full checks, cell commands.
module sia_ctrl #(
  parameter int DEPTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  logic [sia_pkg::OP_W-1:0]    op,
  input  logic [sia_pkg::POS_W-1:0]   pos,
  input  logic                        cfg_we,
  input  logic [sia_pkg::CNT_W-1:0]   cfg_cap,
  output sia_pkg::cell_ctrl_t         cell_ctrl,
  output sia_pkg::ctrl_res_t          res
);
  import sia_pkg::*;

  localparam int CapLimit = (DEPTH > 63) ? 63 : DEPTH;

  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] cap_eff;
  logic             full;
  logic             pos_le;
  logic             pos_lt;
  status_t          status;
  logic             rd_hit;
  cell_ctrl_t       cmd;

  assign cap_eff = (cap_r > CNT_W'(CapLimit)) ? CNT_W'(CapLimit) : cap_r;
  assign full    = (count_r >= cap_eff);
  assign pos_le  = (pos <= count_r);
  assign pos_lt  = (pos < count_r);

  always_comb begin
    count_nxt = count_r;
    status    = ST_OK;
    rd_hit    = 1'b0;
    cmd.cmd   = CELL_HOLD;
    cmd.tgt   = pos;
    case (op_t'(op))
      OP_INSERT: begin
        // index check comes before the full check
        if (!pos_le) begin
          status = ST_BAD_INDEX;
        end else if (full) begin
          status = ST_OVERFLOW;
        end else begin
          cmd.cmd   = CELL_INSERT;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_APPEND: begin
        if (full) begin
          status = ST_OVERFLOW;
        end else begin
          cmd.cmd   = CELL_WRITE;
          cmd.tgt   = count_r;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_READ: begin
        if (!pos_lt) status = ST_BAD_INDEX;
        else         rd_hit = 1'b1;
      end
      OP_EDIT: begin
        if (!pos_lt) status = ST_BAD_INDEX;
        else         cmd.cmd = CELL_WRITE;
      end
      OP_DELETE: begin
        if (!pos_lt) begin
          status = ST_BAD_INDEX;
        end else begin
          cmd.cmd   = CELL_DELETE;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_comb begin
    cell_ctrl = cmd;
    if (!acc) cell_ctrl.cmd = CELL_HOLD;
    res.meta.status     = status;
    res.meta.fill_count = count_nxt;
    res.meta.is_empty   = (count_nxt == '0);
    res.meta.is_full    = (count_nxt >= cap_eff);
    res.rd_hit          = rd_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= '0;
      count_r <= '0;
    end else if (cfg_we) begin
      // new capacity empties the list
      cap_r   <= cfg_cap;
      count_r <= '0;
    end else if (acc) begin
      count_r <= count_nxt;
    end
  end

endmodule

// File: sv/sia_checker.sv
// Port-level checker for the shift-insert array table, bound to the top level.
`include "shift_insert_array_table_defines.svh"

module sia_checker #(
  parameter int DATA_WIDTH = sia_pkg::DATA_WIDTH_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [sia_pkg::OP_W-1:0]   in_opcode,
  input logic [sia_pkg::POS_W-1:0]  in_position,
  input logic [DATA_WIDTH-1:0]      in_item_value,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [sia_pkg::ST_W-1:0]   out_status,
  input logic [DATA_WIDTH-1:0]      out_read_data,
  input logic [sia_pkg::CNT_W-1:0]  out_fill_count,
  input logic                       out_is_empty,
  input logic                       out_is_full
);
  import sia_pkg::*;

  // a stalled input word holds
  `SIA_CHECK(a_in_hold,
    (in_valid && in_stall) |=> (in_valid && $stable(in_opcode)
      && $stable(in_position) && $stable(in_item_value)),
    "input word changed while stalled")

  // a stalled result word holds
  `SIA_CHECK(a_out_hold,
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)
      && $stable(out_read_data) && $stable(out_fill_count)),
    "result word changed while stalled")

  `SIA_IMPLY(a_empty_flag, out_valid,
    (out_is_empty == (out_fill_count == '0)),
    "empty flag disagrees with fill count")

  // any error drops the read data to all ones
  `SIA_IMPLY(a_err_data, (out_valid && (out_status != ST_OK)),
    (out_read_data == '1),
    "error result carries read data")

  `SIA_IMPLY(a_ovf_full, (out_valid && (out_status == ST_OVERFLOW)),
    out_is_full,
    "overflow reported while list not full")

endmodule

bind shift_insert_array_table sia_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_sia_checker (.*);

// File: tb/shift_insert_array_table_test.sv
// Self-checking testbench of the shift-insert array table: scripted and random list operations.
`timescale 1ns / 100ps

module shift_insert_array_table_test;
  import sia_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  localparam int DW = DATA_WIDTH_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
  localparam logic [DW-1:0] NO_DATA = '1;
  localparam logic [CNT_W-1:0] CAP_MAX = '1;
  localparam int MAX_WAIT = 12;
  localparam int RANDOM_PHASES = 12;
  localparam int WORDS_PER_PHASE = 140;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    status_t          status;
    logic [DW-1:0]    rdata;
    logic [CNT_W-1:0] fill_count;
    logic             is_empty;
    logic             is_full;
  } list_result_t;

  typedef struct packed {
    logic             is_cfg;
    logic [CNT_W-1:0] cap;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [DW-1:0]    val;
    logic             fixed;
    list_result_t     res;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_opcode = '0;
  logic [POS_W-1:0] in_position = '0;
  logic [DW-1:0] in_item_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ST_W-1:0] out_status;
  logic [DW-1:0] out_read_data;
  logic [CNT_W-1:0] out_fill_count;
  logic out_is_empty;
  logic out_is_full;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_capacity_in_use = '0;

  // Sideband that travels with each input word.
  logic word_fixed = 1'b0;
  list_result_t word_expect = '0;

  // Shadow copy of the list.
  logic [DW-1:0] shadow_list [LIST_DEPTH];
  int unsigned shadow_held = 0;
  int unsigned shadow_cap = 0;

  list_result_t pending_results [$];
  script_row_t script [$];
  int outstanding = 0;
  int unsigned fill_hint = 0;
  logic no_idle = 1'b0;
  int stall_left = 0;
  int mismatch_count = 0;
  int checked_words = 0;
  int cap_writes = 0;
  int overflow_seen = 0;
  int bad_index_seen = 0;
  int idle_cycles = 0;

  shift_insert_array_table dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_position         (in_position),
    .in_item_value       (in_item_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_read_data       (out_read_data),
    .out_fill_count      (out_fill_count),
    .out_is_empty        (out_is_empty),
    .out_is_full         (out_is_full),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_capacity_in_use (cfg_capacity_in_use)
  );

  always #10 clk = ~clk;

  function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [DW-1:0] val);
    list_result_t r;
    int unsigned limit;
    bit at_cap;
    limit = (shadow_cap > LIST_DEPTH) ? LIST_DEPTH : shadow_cap;
    at_cap = (shadow_held >= limit);
    r.status = ST_OK;
    r.rdata = NO_DATA;
    case (op)
      OP_INSERT: begin
        if (pos > shadow_held) begin
          r.status = ST_BAD_INDEX;
        end else if (at_cap) begin
          r.status = ST_OVERFLOW;
        end else begin
          for (int i = shadow_held; i > pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = val;
          shadow_held++;
        end
      end
      OP_APPEND: begin
        if (at_cap) begin
          r.status = ST_OVERFLOW;
        end else begin
          shadow_list[shadow_held] = val;
          shadow_held++;
        end
      end
      OP_READ: begin
        if (pos >= shadow_held) r.status = ST_BAD_INDEX;
        else r.rdata = shadow_list[pos];
      end
      OP_EDIT: begin
        if (pos >= shadow_held) r.status = ST_BAD_INDEX;
        else shadow_list[pos] = val;
      end
      OP_DELETE: begin
        if (pos >= shadow_held) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (int i = pos; i + 1 < shadow_held; i++) shadow_list[i] = shadow_list[i+1];
          shadow_held--;
        end
      end
      default: begin
      end
    endcase
    r.fill_count = CNT_W'(shadow_held);
    r.is_empty = (shadow_held == 0);
    r.is_full = (shadow_held >= limit);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    $display("mismatch on %s at result %0d: got %h, want %h", field, checked_words, got, want);
    mismatch_count++;
  endtask

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Script helpers.
  function automatic void cap_row(input logic [CNT_W-1:0] cap);
    script_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cap = cap;
    script.push_back(row);
  endfunction

  function automatic void step_row(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                   input logic [DW-1:0] val);
    script_row_t row;
    row = '0;
    row.op = op;
    row.pos = pos;
    row.val = val;
    script.push_back(row);
  endfunction

  function automatic void fixed_row(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                    input logic [DW-1:0] val, input status_t st,
                                    input logic [DW-1:0] rd, input int fill,
                                    input bit empty, input bit full);
    script_row_t row;
    row = '0;
    row.op = op;
    row.pos = pos;
    row.val = val;
    row.fixed = 1'b1;
    row.res.status = st;
    row.res.rdata = rd;
    row.res.fill_count = CNT_W'(fill);
    row.res.is_empty = empty;
    row.res.is_full = full;
    script.push_back(row);
  endfunction

  function automatic logic [OP_W-1:0] pick_opcode(input bit growing);
    int r;
    r = $urandom_range(0, 99);
    if (r >= 97) return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    if (growing) begin
      if (r < 30) return OP_INSERT;
      if (r < 55) return OP_APPEND;
      if (r < 72) return OP_READ;
      if (r < 84) return OP_EDIT;
      return OP_DELETE;
    end
    if (r < 10) return OP_INSERT;
    if (r < 20) return OP_APPEND;
    if (r < 40) return OP_READ;
    if (r < 55) return OP_EDIT;
    return OP_DELETE;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 9);
    // Mostly aim inside the list as last seen.
    if (r < 7) return POS_W'($urandom_range(0, fill_hint));
    if (r < 9) return POS_W'($urandom_range(0, LIST_DEPTH));
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  function automatic logic [DW-1:0] pick_value();
    if ($urandom_range(0, 9) != 0) return DW'($urandom);
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [DW-1:0] val, input logic fixed,
                           input list_result_t res);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_position <= pos;
    in_item_value <= val;
    word_fixed <= fixed;
    word_expect <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Write only once the block has drained.
  task automatic write_capacity(input logic [CNT_W-1:0] cap);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_capacity_in_use <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: stall a random number of cycles after every accepted word.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) stall_left = draw_wait();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check results against the oldest expectation, then predict new words.
  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.status = status_t'(out_status);
        got.rdata = out_read_data;
        got.fill_count = out_fill_count;
        got.is_empty = out_is_empty;
        got.is_full = out_is_full;
        if (got.status == ST_OVERFLOW) overflow_seen++;
        if (got.status == ST_BAD_INDEX) bad_index_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result word", got.rdata, '0);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (got.rdata !== want.rdata) report_mismatch("read_data", got.rdata, want.rdata);
          if (got.fill_count !== want.fill_count)
            report_mismatch("fill_count", got.fill_count, want.fill_count);
          if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", got.is_empty, want.is_empty);
          if (got.is_full !== want.is_full) report_mismatch("is_full", got.is_full, want.is_full);
        end
        checked_words++;
      end
      if (in_valid && !in_stall) begin
        want = apply_list_op(in_opcode, in_position, in_item_value);
        pending_results.push_back(word_fixed ? word_expect : want);
      end
      if (cfg_valid && cfg_ready) begin
        shadow_cap = cfg_capacity_in_use;
        shadow_held = 0;
        cap_writes++;
      end
    end
    outstanding <= pending_results.size();
    fill_hint <= shadow_held;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("shift_insert_array_table verification failed");
      $finish;
    end
  end

  initial begin
    script_row_t row;
    logic [CNT_W-1:0] cap;
    bit growing;
    int run_left;

    // Capacity zero straight after reset: empty and full at once.
    fixed_row(OP_APPEND, 0, 32'h7fff_ffff, ST_OVERFLOW, NO_DATA, 0, 1, 1);
    fixed_row(OP_INSERT, 0, 32'h0, ST_OVERFLOW, NO_DATA, 0, 1, 1);
    fixed_row(OP_INSERT, 1, 32'h0, ST_BAD_INDEX, NO_DATA, 0, 1, 1);
    fixed_row(OP_READ, 0, 32'h0, ST_BAD_INDEX, NO_DATA, 0, 1, 1);
    fixed_row(OP_DELETE, 63, 32'h0, ST_BAD_INDEX, NO_DATA, 0, 1, 1);
    fixed_row(OP_UNUSED_LO, 0, 32'h0, ST_OK, NO_DATA, 0, 1, 1);
    fixed_row(OP_UNUSED_HI, 63, 32'hffff_ffff, ST_OK, NO_DATA, 0, 1, 1);
    cap_row(3);
    fixed_row(OP_APPEND, 0, 32'h7fff_ffff, ST_OK, NO_DATA, 1, 0, 0);
    fixed_row(OP_INSERT, 0, 32'h8000_0000, ST_OK, NO_DATA, 2, 0, 0);
    fixed_row(OP_READ, 0, 32'h0, ST_OK, 32'h8000_0000, 2, 0, 0);
    fixed_row(OP_READ, 1, 32'h0, ST_OK, 32'h7fff_ffff, 2, 0, 0);
    step_row(OP_INSERT, 1, 32'h1234_5678);
    // Full list: index passes, so the full check answers.
    fixed_row(OP_INSERT, 1, 32'h0, ST_OVERFLOW, NO_DATA, 3, 0, 1);
    fixed_row(OP_APPEND, 0, 32'h0, ST_OVERFLOW, NO_DATA, 3, 0, 1);
    fixed_row(OP_INSERT, 4, 32'h0, ST_BAD_INDEX, NO_DATA, 3, 0, 1);
    fixed_row(OP_READ, 3, 32'h0, ST_BAD_INDEX, NO_DATA, 3, 0, 1);
    step_row(OP_READ, 1, 32'h0);
    step_row(OP_EDIT, 2, 32'hffff_ffff);
    step_row(OP_DELETE, 0, 32'h0);
    step_row(OP_READ, 1, 32'h0);
    fixed_row(OP_EDIT, 2, 32'h0, ST_BAD_INDEX, NO_DATA, 2, 0, 0);
    // Above the row size: capacity saturates.
    cap_row(CAP_MAX);
    step_row(OP_APPEND, 0, 32'haaaa_5555);
    fixed_row(OP_INSERT, 63, 32'h0, ST_BAD_INDEX, NO_DATA, 1, 0, 0);
    step_row(OP_DELETE, 0, 32'h0);
    cap_row(1);
    step_row(OP_APPEND, 0, 32'h5555_aaaa);
    step_row(OP_EDIT, 0, 32'h0);
    step_row(OP_READ, 0, 32'h0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    while (script.size() != 0) begin
      row = script.pop_front();
      if (row.is_cfg) write_capacity(row.cap);
      else send_word(row.op, row.pos, row.val, row.fixed, row.res);
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: cap = 1;
        1: cap = CNT_W'(LIST_DEPTH);
        2: cap = CAP_MAX;
        3: cap = 0;
        4: cap = 2;
        default: cap = ($urandom_range(0, 1) == 0) ? CNT_W'($urandom_range(3, 8))
                                                   : CNT_W'($urandom_range(0, CAP_MAX));
      endcase
      write_capacity(cap);
      no_idle <= ($urandom_range(0, 3) == 0);
      growing = 1'b1;
      run_left = $urandom_range(20, 60);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // Swing between filling and draining the list.
        if (run_left == 0) begin
          growing = !growing;
          run_left = $urandom_range(20, 60);
        end
        run_left--;
        send_word(pick_opcode(growing), pick_position(), pick_value(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("checked %0d result words across %0d capacity writes", checked_words, cap_writes);
    $display("replies seen: %0d overflow, %0d invalid index", overflow_seen, bad_index_seen);
    if (mismatch_count == 0) begin
      $display("shift_insert_array_table verification clean");
    end else begin
      $display("shift_insert_array_table verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/sia_pkg.sv
sv/sia_cell.sv
sv/sia_ctrl.sv
sv/shift_insert_array_table.sv
sv/sia_checker.sv
tb/shift_insert_array_table_test.sv
